@@ hdl/mcodp_pkg.sv @@
package mcodp_pkg;

    localparam int PC_BITS = 4;
    localparam int OP_BITS = 4;
    localparam int JC_BITS = 3;
    localparam int DS_BITS = 2;

    typedef logic [PC_BITS-1:0] t_pc;

    typedef struct packed {
        logic [DS_BITS-1:0] dsel;
        logic [OP_BITS-1:0] op;
        logic [JC_BITS-1:0] cond;
        t_pc                target;
    } t_uop;

    localparam logic [DS_BITS-1:0] DSEL_NONE = 2'd0;
    localparam logic [DS_BITS-1:0] DSEL_I    = 2'd1;
    localparam logic [DS_BITS-1:0] DSEL_J1   = 2'd2;
    localparam logic [DS_BITS-1:0] DSEL_K1   = 2'd3;

    localparam logic [OP_BITS-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_BITS-1:0] OP_INIT   = 4'd1;
    localparam logic [OP_BITS-1:0] OP_KINIT  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_LDDI   = 4'd3;
    localparam logic [OP_BITS-1:0] OP_LDPIJ  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_MULSUM = 4'd5;
    localparam logic [OP_BITS-1:0] OP_CMP    = 4'd6;
    localparam logic [OP_BITS-1:0] OP_EMIT   = 4'd7;
    localparam logic [OP_BITS-1:0] OP_NEXT   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_EMIT1  = 4'd9;

    localparam logic [JC_BITS-1:0] J_NEVER  = 3'd0;
    localparam logic [JC_BITS-1:0] J_ALWAYS = 3'd1;
    localparam logic [JC_BITS-1:0] J_NOGO   = 3'd2;
    localparam logic [JC_BITS-1:0] J_SINGLE = 3'd3;
    localparam logic [JC_BITS-1:0] J_KMORE  = 3'd4;
    localparam logic [JC_BITS-1:0] J_LAST   = 3'd5;

    localparam t_pc P_IDLE  = 4'd0;
    localparam t_pc P_INIT  = 4'd1;
    localparam t_pc P_SUB   = 4'd2;
    localparam t_pc P_DJ    = 4'd3;
    localparam t_pc P_PIJ   = 4'd4;
    localparam t_pc P_SPLIT = 4'd5;
    localparam t_pc P_MUL   = 4'd6;
    localparam t_pc P_CMP   = 4'd7;
    localparam t_pc P_EMIT  = 4'd8;
    localparam t_pc P_NEXT  = 4'd9;
    localparam t_pc P_ONE   = 4'd10;

    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        u = '{dsel: DSEL_NONE, op: OP_NOP, cond: J_ALWAYS, target: P_IDLE};
        case (pc)
            P_IDLE:  u = '{dsel: DSEL_NONE, op: OP_NOP,    cond: J_NOGO,   target: P_IDLE};
            P_INIT:  u = '{dsel: DSEL_NONE, op: OP_INIT,   cond: J_SINGLE, target: P_ONE};
            P_SUB:   u = '{dsel: DSEL_I,    op: OP_KINIT,  cond: J_NEVER,  target: P_IDLE};
            P_DJ:    u = '{dsel: DSEL_J1,   op: OP_LDDI,   cond: J_NEVER,  target: P_IDLE};
            P_PIJ:   u = '{dsel: DSEL_NONE, op: OP_LDPIJ,  cond: J_NEVER,  target: P_IDLE};
            P_SPLIT: u = '{dsel: DSEL_K1,   op: OP_NOP,    cond: J_NEVER,  target: P_IDLE};
            P_MUL:   u = '{dsel: DSEL_NONE, op: OP_MULSUM, cond: J_NEVER,  target: P_IDLE};
            P_CMP:   u = '{dsel: DSEL_NONE, op: OP_CMP,    cond: J_KMORE,  target: P_SPLIT};
            P_EMIT:  u = '{dsel: DSEL_NONE, op: OP_EMIT,   cond: J_LAST,   target: P_IDLE};
            P_NEXT:  u = '{dsel: DSEL_NONE, op: OP_NEXT,   cond: J_ALWAYS, target: P_SUB};
            P_ONE:   u = '{dsel: DSEL_NONE, op: OP_EMIT1,  cond: J_ALWAYS, target: P_IDLE};
            default: u = '{dsel: DSEL_NONE, op: OP_NOP,    cond: J_ALWAYS, target: P_IDLE};
        endcase
        return u;
    endfunction

endpackage

@@ hdl/matrix_chain_order_dp_core.sv @@
// Dimension beats are taken one per cycle while the sequencer is idle; a result beat
// waiting in the output register stalls only the emit steps.
// After the beat flagged last, a start step runs; each subchain then loads its dimensions,
// walks the three-step split loop (split, multiply, compare) once per split point and
// emits its result, while a single matrix goes straight to one zero-cost result.
// Synchronous active-low reset clears only the step counter, dimension count and valid.
module matrix_chain_order_dp_core
    import mcodp_pkg::*;
#(
    parameter int MAX_MATRICES = 8,
    parameter int DIM_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_dim_value,
    input  logic        i_last_dim,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_row,
    output logic [2:0]  o_col,
    output logic [31:0] o_cost,
    output logic [3:0]  o_split_point,
    output logic        o_last_result
);

    localparam int DEPTH = MAX_MATRICES + 1;
    localparam int TDEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int DAW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(MAX_MATRICES);
    localparam int CAW = $clog2(TDEPTH);
    localparam int QW = 2 * DIM_BITS;
    localparam int PW = 3 * DIM_BITS;
    localparam int SW = ((PW > 33) ? PW : 33) + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CAW-1:0] ROW_STRIDE = CAW'(MAX_MATRICES);
    localparam logic [SW-1:0] SAT_LIM = SW'(33'h0_FFFF_FFFF);

    logic [DIM_BITS-1:0] r_dim_mem [DEPTH];
    logic [31:0]         r_cost_mem [TDEPTH];

    t_pc                 r_pc, n_pc;
    t_uop                w_uop;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [DAW-1:0]      r_n;
    logic [IW-1:0]       r_i, r_j, r_k, r_diag, r_bestk;
    logic [31:0]         r_best;
    logic [DIM_BITS-1:0] r_dq, r_di;
    logic [QW-1:0]       r_pij;
    logic [PW-1:0]       r_prod;
    logic [32:0]         r_sab;
    logic [31:0]         r_ca, r_cb;
    logic                r_za, r_zb;

    logic                r_ov;
    logic [2:0]          r_row, r_col;
    logic [31:0]         r_cost;
    logic [3:0]          r_split;
    logic                r_last;

    logic                w_in_acc, w_store, w_go, w_slot, w_hold, w_take;
    logic                w_last_sub, w_kmore, w_jend, w_better;
    logic [CW-1:0]       w_cnt_after;
    logic [DAW-1:0]      w_dim_addr;
    logic [CAW-1:0]      w_ca_addr, w_cb_addr, w_wr_addr;
    logic [31:0]         w_ca_m, w_cb_m, w_sat;
    logic [SW-1:0]       w_sum;

    assign w_uop       = ucode(r_pc);
    assign o_in_ready  = (r_pc == P_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_store     = (r_cnt != CNT_FULL);
    assign w_cnt_after = r_cnt + CW'(w_store);
    assign w_go        = w_in_acc && i_last_dim && (w_cnt_after >= CW'(2));
    assign w_slot      = !r_ov || i_out_ready;
    assign w_hold      = ((w_uop.op == OP_EMIT) || (w_uop.op == OP_EMIT1)) && !w_slot;
    assign w_last_sub  = ((DAW'(r_diag) + DAW'(1)) == r_n);
    assign w_kmore     = ((r_k + IW'(1)) != r_j);
    assign w_jend      = ((DAW'(r_j) + DAW'(1)) == r_n);

    always_comb begin
        case (w_uop.cond)
            J_NEVER:  w_take = 1'b0;
            J_ALWAYS: w_take = 1'b1;
            J_NOGO:   w_take = !w_go;
            J_SINGLE: w_take = (r_n == DAW'(1));
            J_KMORE:  w_take = w_kmore;
            J_LAST:   w_take = w_last_sub;
            default:  w_take = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uop.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc) begin
            n_cnt = i_last_dim ? '0 : w_cnt_after;
        end
    end

    always_comb begin
        case (w_uop.dsel)
            DSEL_I:  w_dim_addr = DAW'(r_i);
            DSEL_J1: w_dim_addr = DAW'(r_j) + DAW'(1);
            DSEL_K1: w_dim_addr = DAW'(r_k) + DAW'(1);
            default: w_dim_addr = '0;
        endcase
    end

    assign w_ca_addr = CAW'(r_i) * ROW_STRIDE + CAW'(r_k);
    assign w_cb_addr = CAW'(r_k + IW'(1)) * ROW_STRIDE + CAW'(r_j);
    assign w_wr_addr = CAW'(r_i) * ROW_STRIDE + CAW'(r_j);

    assign w_ca_m   = r_za ? 32'd0 : r_ca;
    assign w_cb_m   = r_zb ? 32'd0 : r_cb;
    assign w_sum    = SW'(r_sab) + SW'(r_prod);
    assign w_sat    = (w_sum > SAT_LIM) ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_better = (r_k == r_i) || (w_sat < r_best);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_store) begin
            r_dim_mem[r_cnt[DAW-1:0]] <= DIM_BITS'(i_dim_value);
        end
        r_dq <= r_dim_mem[w_dim_addr];
    end

    always_ff @(posedge i_clk) begin
        if ((w_uop.op == OP_EMIT) && !w_hold) begin
            r_cost_mem[w_wr_addr] <= r_best;
        end
        r_ca <= r_cost_mem[w_ca_addr];
        r_cb <= r_cost_mem[w_cb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= P_IDLE;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
            if (((w_uop.op == OP_EMIT) || (w_uop.op == OP_EMIT1)) && !w_hold) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_dim) begin
            r_n <= DAW'(w_cnt_after - CW'(1));
        end
        if (w_uop.dsel == DSEL_K1) begin
            r_za <= (r_k == r_i);
            r_zb <= ((r_k + IW'(1)) == r_j);
        end
        if (!w_hold) begin
            case (w_uop.op)
                OP_INIT: begin
                    r_i    <= '0;
                    r_j    <= IW'(1);
                    r_diag <= IW'(1);
                end
                OP_KINIT: begin
                    r_k <= r_i;
                end
                OP_LDDI: begin
                    r_di <= r_dq;
                end
                OP_LDPIJ: begin
                    r_pij <= QW'(r_di) * QW'(r_dq);
                end
                OP_MULSUM: begin
                    r_prod <= PW'(r_pij) * PW'(r_dq);
                    r_sab  <= {1'b0, w_ca_m} + {1'b0, w_cb_m};
                end
                OP_CMP: begin
                    if (w_better) begin
                        r_best  <= w_sat;
                        r_bestk <= r_k;
                    end
                    r_k <= r_k + IW'(1);
                end
                OP_EMIT: begin
                    r_row   <= 3'(r_i);
                    r_col   <= 3'(r_j);
                    r_cost  <= r_best;
                    r_split <= 4'(r_bestk) + 4'd1;
                    r_last  <= w_last_sub;
                end
                OP_NEXT: begin
                    if (w_jend) begin
                        r_diag <= r_diag + IW'(1);
                        r_i    <= '0;
                        r_j    <= r_diag + IW'(1);
                    end else begin
                        r_i <= r_i + IW'(1);
                        r_j <= r_j + IW'(1);
                    end
                end
                OP_EMIT1: begin
                    r_row   <= 3'd0;
                    r_col   <= 3'd0;
                    r_cost  <= 32'd0;
                    r_split <= 4'd0;
                    r_last  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_row         = r_row;
    assign o_col         = r_col;
    assign o_cost        = r_cost;
    assign o_split_point = r_split;
    assign o_last_result = r_last;

endmodule

@@ hdl/mcodp_checker.sv @@
module mcodp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_row,
    input logic [2:0]  o_col,
    input logic [31:0] o_cost,
    input logic [3:0]  o_split_point,
    input logic        o_last_result
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result beat valid right after reset.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cost) && $stable(o_row)
            && $stable(o_col) && $stable(o_split_point) && $stable(o_last_result))
        else $error("Stalled result beat changed.");

    a_row_le_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_row <= o_col)
        else $error("Result row exceeds column.");

    a_split_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_row != o_col) |->
            ({1'b0, o_row} < o_split_point) && (o_split_point <= {1'b0, o_col}))
        else $error("Split point outside its subchain.");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_row == o_col) |->
            (o_cost == 32'd0) && (o_split_point == 4'd0) && o_last_result)
        else $error("Single matrix result malformed.");

endmodule

bind matrix_chain_order_dp_core mcodp_checker u_mcodp_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bit [2:0]  row;
        bit [2:0]  col;
        bit [31:0] cost;
        bit [3:0]  split;
        bit        last;
    } t_subchain_cost;

    localparam int CHAIN_DIMS_MAX = 9;
    localparam int MATRICES_MAX   = 8;
    localparam bit [63:0] COST_CEILING = 64'h0000_0000_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_dim_value;
    logic        i_last_dim;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_row;
    logic [2:0]  o_col;
    logic [31:0] o_cost;
    logic [3:0]  o_split_point;
    logic        o_last_result;

    bit [7:0]       chain_dims [CHAIN_DIMS_MAX];
    int             dims_held = 0;
    t_subchain_cost owed_costs [$];
    int             mismatches = 0;
    int             beats_sent = 0;
    bit             idle_on = 1'b1;

    matrix_chain_order_dp_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_dim_value   (i_dim_value),
        .i_last_dim    (i_last_dim),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_cost        (o_cost),
        .o_split_point (o_split_point),
        .o_last_result (o_last_result)
    );

    always #1 i_clk = ~i_clk;

    // Dimension beats past the ninth are dropped, but the flag still closes the chain.
    task automatic absorb_dim(input bit [7:0] dim, input bit closes);
        bit [31:0]      best_cost [MATRICES_MAX][MATRICES_MAX];
        bit [63:0]      da, db, dc, total, best;
        int             n, j, best_k;
        t_subchain_cost res;
        if (dims_held < CHAIN_DIMS_MAX) begin
            chain_dims[dims_held] = dim;
            dims_held++;
        end
        if (!closes) return;
        n = dims_held - 1;
        dims_held = 0;
        if (n < 1) return;
        if (n == 1) begin
            res = '0;
            res.last = 1'b1;
            owed_costs.push_back(res);
            return;
        end
        for (int i = 0; i < n; i++) best_cost[i][i] = '0;
        for (int d = 1; d < n; d++) begin
            for (int i = 0; i + d < n; i++) begin
                j = i + d;
                best = '0;
                best_k = i;
                for (int k = i; k < j; k++) begin
                    da = chain_dims[i];
                    db = chain_dims[k + 1];
                    dc = chain_dims[j + 1];
                    total = best_cost[i][k] + best_cost[k + 1][j] + da * db * dc;
                    if (total > COST_CEILING) total = COST_CEILING;
                    if (k == i || total < best) begin
                        best = total;
                        best_k = k;
                    end
                end
                best_cost[i][j] = best[31:0];
                res.row   = i[2:0];
                res.col   = j[2:0];
                res.cost  = best[31:0];
                res.split = 4'(best_k + 1);
                res.last  = (d == n - 1);
                owed_costs.push_back(res);
            end
        end
    endtask

    task automatic log_mismatch(input string what, input t_subchain_cost want,
                                input t_subchain_cost got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected row %0d col %0d cost %0d split %0d last %0d,",
                     $realtime, what, want.row, want.col, want.cost, want.split,
                     want.last);
            $display("    got row %0d col %0d cost %0d split %0d last %0d",
                     got.row, got.col, got.cost, got.split, got.last);
        end
    endtask

    always @(posedge i_clk) begin : check_beat
        t_subchain_cost want;
        t_subchain_cost got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_row, o_col, o_cost, o_split_point, o_last_result};
            if (owed_costs.size() == 0) begin
                log_mismatch("unexpected result", '0, got);
            end else begin
                want = owed_costs.pop_front();
                if (want != got) log_mismatch("wrong result", want, got);
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic bit [7:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'd255;
            2:       return 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_dim(input bit [7:0] dim, input bit closes);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_dim_value <= dim;
        i_last_dim  <= closes;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_dim(dim, closes);
        beats_sent++;
    endtask

    task automatic send_chain(input int dims);
        for (int d = 0; d < dims; d++) send_dim(pick_dim(), d == dims - 1);
    endtask

    task automatic test_directed_cases();
        send_dim(8'd7, 1'b0);
        send_dim(8'd200, 1'b1);
        send_dim(8'd5, 1'b1);
        send_dim(8'd10, 1'b0);
        send_dim(8'd20, 1'b0);
        send_dim(8'd30, 1'b1);
        for (int d = 0; d < CHAIN_DIMS_MAX; d++) send_dim(8'd255, d == CHAIN_DIMS_MAX - 1);
        for (int d = 0; d < CHAIN_DIMS_MAX; d++) send_dim((d % 2) ? 8'd0 : 8'(d + 1), 1'b0);
        send_dim(8'd77, 1'b1);
    endtask

    task automatic test_random_chains();
        while (beats_sent < 110) send_chain($urandom_range(2, CHAIN_DIMS_MAX));
    endtask

    task automatic test_broken_sequences();
        repeat (6) begin
            if ($urandom_range(0, 1) == 0) send_dim(pick_dim(), 1'b1);
            else send_chain($urandom_range(CHAIN_DIMS_MAX + 1, CHAIN_DIMS_MAX + 4));
            send_chain($urandom_range(2, 4));
        end
    endtask

    task automatic test_steady_flow();
        idle_on = 1'b0;
        while (beats_sent < 180) send_chain($urandom_range(2, CHAIN_DIMS_MAX));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_dim_value <= '0;
        i_last_dim  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_chains();
        test_broken_sequences();
        test_steady_flow();
        i_in_valid <= 1'b0;
        while (owed_costs.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
